/* hw/rtl/vpid_pkg.sv */
// Shared types, constants and the operation sequence of the vehicle PID core.
package vpid_pkg;

  // Field and datapath widths.
  localparam int SPD_W  = 16;
  localparam int DEV_W  = 16;
  localparam int TIME_W = 20;
  localparam int GAIN_W = 16;
  localparam int LIM_W  = 21;
  localparam int OUT_W  = 16;
  localparam int FLT_W  = 2;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 21;

  localparam int ERR_W  = 32;
  localparam int DD_W   = 38;
  localparam int MA_W   = 39;
  localparam int MB_W   = 21;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = 62;
  localparam int DIV_W  = 52;
  localparam int DVS_W  = 20;
  localparam int QUO_W  = DIV_W + 1;
  localparam int CNT_W  = 6;
  localparam int STEP_W = 6;

  // Division by one million as a shift by 6 and a division by 15625. The
  // shifted magnitude (below 2^44) is divided by a reciprocal multiplication
  // on its top 30 bits, refined once on the remainder and finished by one
  // compare and increment.
  localparam int RQ_SH_IN = 6;
  localparam int RQ_Y_W   = 44;
  localparam int RQ_PRE   = 14;
  localparam int RQ_SH0   = 19;
  localparam int RQ_SH1   = 33;
  localparam int RQ_REM_W = 25;
  localparam int RQ_Q1_W  = 12;
  // Reciprocal is floor(2^33 / 15625).
  localparam logic [DVS_W-1:0] RQ_RECIP = 20'd549755;
  localparam logic [DVS_W-1:0] RQ_DIV   = 20'd15625;

  // Arithmetic constants.
  localparam logic [DVS_W-1:0] US_PER_S    = 20'd1000000;
  localparam logic [OUT_W-1:0] THR_MAX     = 16'd26214;
  localparam logic [OUT_W-1:0] BRK_MAX     = 16'd32768;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 21'd81920;

  // Register indexes of the configuration port.
  localparam logic [CIDX_W-1:0] CFG_SPEED_KP = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SPEED_KI = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SPEED_KD = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_STEER_KP = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_STEER_KI = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_STEER_KD = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_LIMIT    = 3'd6;

  // Datapath operations issued by the sequencer.
  typedef enum logic [5:0] {
    OP_NOP, OP_DIV_E, OP_WR_E, OP_MUL_ET, OP_RQ_LOAD, OP_RQ_MUL0, OP_RQ_MULQ0,
    OP_RQ_R0, OP_RQ_MUL1, OP_RQ_MULQ1, OP_RQ_R1, OP_RQ_FIN, OP_WR_SI, OP_CLAMP_SI,
    OP_MUL_DT, OP_WR_HI, OP_SUB_E, OP_MUL_DIFF, OP_DIV_DE, OP_WR_DE,
    OP_SUB_D, OP_DIV_DD, OP_WR_DD, OP_MUL_SKP, OP_MUL_SKI, OP_MUL_SKD,
    OP_ACC_FIRST, OP_ACC_ADD, OP_SCALE_SPD, OP_SPEED_OUT, OP_MUL_TKP,
    OP_MUL_TKI, OP_MUL_TKD, OP_SCALE_STR, OP_STEER_OUT, OP_PUBLISH
  } op_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT_DIV} state_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

  // Operation at each step of the per-item program.
  function automatic op_t seq_op(input logic [STEP_W-1:0] step);
    op_t op;
    unique case (step)
      6'd0:  op = OP_DIV_E;
      6'd1:  op = OP_WR_E;
      6'd2:  op = OP_MUL_ET;
      6'd3:  op = OP_RQ_LOAD;
      6'd4:  op = OP_RQ_MUL0;
      6'd5:  op = OP_RQ_MULQ0;
      6'd6:  op = OP_RQ_R0;
      6'd7:  op = OP_RQ_MUL1;
      6'd8:  op = OP_RQ_MULQ1;
      6'd9:  op = OP_RQ_R1;
      6'd10: op = OP_RQ_FIN;
      6'd11: op = OP_WR_SI;
      6'd12: op = OP_CLAMP_SI;
      6'd13: op = OP_MUL_DT;
      6'd14: op = OP_RQ_LOAD;
      6'd15: op = OP_RQ_MUL0;
      6'd16: op = OP_RQ_MULQ0;
      6'd17: op = OP_RQ_R0;
      6'd18: op = OP_RQ_MUL1;
      6'd19: op = OP_RQ_MULQ1;
      6'd20: op = OP_RQ_R1;
      6'd21: op = OP_RQ_FIN;
      6'd22: op = OP_WR_HI;
      6'd23: op = OP_SUB_E;
      6'd24: op = OP_MUL_DIFF;
      6'd25: op = OP_DIV_DE;
      6'd26: op = OP_WR_DE;
      6'd27: op = OP_SUB_D;
      6'd28: op = OP_MUL_DIFF;
      6'd29: op = OP_DIV_DD;
      6'd30: op = OP_WR_DD;
      6'd31: op = OP_MUL_SKP;
      6'd32: op = OP_ACC_FIRST;
      6'd33: op = OP_MUL_SKI;
      6'd34: op = OP_ACC_ADD;
      6'd35: op = OP_MUL_SKD;
      6'd36: op = OP_ACC_ADD;
      6'd37: op = OP_SCALE_SPD;
      6'd38: op = OP_SPEED_OUT;
      6'd39: op = OP_MUL_TKP;
      6'd40: op = OP_ACC_FIRST;
      6'd41: op = OP_MUL_TKI;
      6'd42: op = OP_ACC_ADD;
      6'd43: op = OP_MUL_TKD;
      6'd44: op = OP_ACC_ADD;
      6'd45: op = OP_SCALE_STR;
      6'd46: op = OP_STEER_OUT;
      6'd47: op = OP_PUBLISH;
      default: op = OP_NOP;
    endcase
    return op;
  endfunction

  function automatic logic is_div_op(input op_t op);
    return (op == OP_DIV_E) || (op == OP_DIV_DE) || (op == OP_DIV_DD);
  endfunction

endpackage

/* hw/rtl/vpid_div.sv */
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module vpid_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [vpid_pkg::PROD_W-1:0] dividend,
  input  logic [vpid_pkg::DVS_W-1:0]        divisor,
  output logic                              done,
  output logic signed [vpid_pkg::QUO_W-1:0] quotient
);
  import vpid_pkg::*;

  logic                    busy_r, busy_nxt;
  logic                    fix_r, fix_nxt;
  logic                    done_r, done_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [DVS_W-1:0]        rem_r, rem_nxt;
  logic [DVS_W-1:0]        dvs_r, dvs_nxt;
  logic [DIV_W-1:0]        quo_r, quo_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [QUO_W-1:0] q_r, q_nxt;
  logic [PROD_W-1:0]       mag;
  logic [DVS_W:0]          rem_sh;
  logic [DVS_W:0]          trial;

  // Magnitude of the dividend and one trial subtraction.
  always_comb begin
    mag    = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
    rem_sh = {rem_r, quo_r[DIV_W-1]};
    trial  = rem_sh - {1'b0, dvs_r};
  end

  // Next state of the iteration.
  always_comb begin
    busy_nxt = busy_r;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = mag[DIV_W-1:0];
      neg_nxt  = dividend[PROD_W-1];
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DVS_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        fix_nxt  = 1'b1;
      end
    end else if (fix_r) begin
      q_nxt    = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* hw/rtl/vpid_ctrl.sv */
// Sequencer that steps the datapath through the per-item program.
module vpid_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vpid_pkg::status_t status,
  output vpid_pkg::cmd_t    cmd
);
  import vpid_pkg::*;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  op_t                cur_op;

  assign cur_op = seq_op(step_r);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd.load  = 1'b0;
    cmd.op    = OP_NOP;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (is_div_op(cur_op)) begin
          cmd.op    = cur_op;
          state_nxt = ST_WAIT_DIV;
        end else if (cur_op == OP_PUBLISH) begin
          // Hold the result until the output register is free.
          if (status.out_free) begin
            cmd.op    = cur_op;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.op   = cur_op;
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_WAIT_DIV: begin
        if (status.div_done) begin
          step_nxt  = step_r + STEP_W'(1);
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

/* hw/rtl/vpid_dp.sv */
// Datapath: configuration, controller state, shared multiplier and output register.
module vpid_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vpid_pkg::cmd_t                      cmd,
  output vpid_pkg::status_t                   status,
  input  logic [vpid_pkg::SPD_W-1:0]          in_measured_speed,
  input  logic [vpid_pkg::SPD_W-1:0]          in_target_speed,
  input  logic signed [vpid_pkg::DEV_W-1:0]   in_heading_deviation,
  input  logic [vpid_pkg::TIME_W-1:0]         in_elapsed_time,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vpid_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [vpid_pkg::CDAT_W-1:0]         cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [vpid_pkg::OUT_W-1:0]          out_throttle,
  output logic [vpid_pkg::OUT_W-1:0]          out_brake,
  output logic signed [vpid_pkg::OUT_W-1:0]   out_steer,
  output logic [vpid_pkg::FLT_W-1:0]          out_divide_fault
);
  import vpid_pkg::*;

  // Configuration registers.
  logic signed [GAIN_W-1:0] skp_r, ski_r, skd_r, tkp_r, tki_r, tkd_r;
  logic [LIM_W-1:0]         lim_r;

  // Item and controller state.
  logic [SPD_W-1:0]         meas_r, targ_r;
  logic signed [DEV_W-1:0]  dev_r, ldev_r;
  logic [TIME_W-1:0]        t_r;
  logic [FLT_W-1:0]         fault_r;
  logic signed [ERR_W-1:0]  e_r, lse_r, sint_r, hint_r, de_r;
  logic signed [DD_W-1:0]   dd_r;
  logic signed [MA_W-1:0]   diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [OUT_W-1:0]         thr_r, brk_r;
  logic signed [OUT_W-1:0]  str_r;

  // Division by one million.
  logic [RQ_Y_W-1:0]        rq_y_r;
  logic                     rq_neg_r;
  logic [ERR_W-1:0]         rq_q_r;
  logic [RQ_REM_W-1:0]      rq_rem_r;
  logic signed [ERR_W-1:0]  dq_r;
  logic [PROD_W-1:0]        prod_mag;
  logic                     rq_carry;

  // Output register.
  logic                     ov_r;
  logic [OUT_W-1:0]         othr_r, obrk_r;
  logic signed [OUT_W-1:0]  ostr_r;
  logic [FLT_W-1:0]         oflt_r;

  logic                     targ0, t0;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic                     div_start, div_done;
  logic signed [PROD_W-1:0] div_a;
  logic [DVS_W-1:0]         div_b;
  logic signed [QUO_W-1:0]  quo;
  logic signed [SPD_W:0]    sdiff;
  logic signed [ERR_W:0]    hsum;
  logic signed [ERR_W-1:0]  lim_pos, lim_neg;
  logic signed [ACC_W-1:0]  acc_neg;

  localparam logic signed [ERR_W:0]   I32_MAX = (ERR_W+1)'(33'sh0_7FFF_FFFF);
  localparam logic signed [ERR_W:0]   I32_MIN = -(ERR_W+1)'(33'sh0_8000_0000);
  localparam logic signed [QUO_W-1:0] Q32_MAX = QUO_W'(I32_MAX);
  localparam logic signed [QUO_W-1:0] Q32_MIN = QUO_W'(I32_MIN);
  localparam logic signed [ACC_W-1:0] A_THR   = ACC_W'(THR_MAX);
  localparam logic signed [ACC_W-1:0] A_BRK   = ACC_W'(BRK_MAX);
  localparam logic signed [ACC_W-1:0] A_S_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] A_S_MIN = -ACC_W'(32768);

  assign targ0     = fault_r[0];
  assign t0        = fault_r[1];
  assign cfg_ready = 1'b1;
  assign lim_pos   = $signed({{(ERR_W-LIM_W){1'b0}}, lim_r});
  assign lim_neg   = -lim_pos;
  assign acc_neg   = -acc_r;
  assign hsum      = ERR_W'(hint_r) + (ERR_W+1)'(dq_r);
  assign prod_mag  = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign rq_carry  = rq_rem_r >= RQ_REM_W'(RQ_DIV);

  // Operand selection for the shared multiplier and the divider.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_ET:   begin mul_a = MA_W'(e_r);    mul_b = $signed({1'b0, t_r}); end
      OP_MUL_DT:   begin mul_a = MA_W'(dev_r);  mul_b = $signed({1'b0, t_r}); end
      OP_MUL_DIFF: begin mul_a = diff_r;        mul_b = $signed({1'b0, US_PER_S}); end
      OP_MUL_SKP:  begin mul_a = MA_W'(e_r);    mul_b = MB_W'(skp_r); end
      OP_MUL_SKI:  begin mul_a = MA_W'(sint_r); mul_b = MB_W'(ski_r); end
      OP_MUL_SKD:  begin mul_a = MA_W'(de_r);   mul_b = MB_W'(skd_r); end
      OP_MUL_TKP:  begin mul_a = MA_W'(dev_r);  mul_b = MB_W'(tkp_r); end
      OP_MUL_TKI:  begin mul_a = MA_W'(hint_r); mul_b = MB_W'(tki_r); end
      OP_MUL_TKD:  begin mul_a = MA_W'(dd_r);   mul_b = MB_W'(tkd_r); end
      OP_RQ_MUL0: begin
        mul_a = $signed({{(MA_W-RQ_Y_W+RQ_PRE){1'b0}}, rq_y_r[RQ_Y_W-1:RQ_PRE]});
        mul_b = $signed({1'b0, RQ_RECIP});
      end
      OP_RQ_MULQ0: begin
        mul_a = $signed({{(MA_W-ERR_W){1'b0}}, prod_r[RQ_SH0+ERR_W-1:RQ_SH0]});
        mul_b = $signed({1'b0, RQ_DIV});
      end
      OP_RQ_MUL1: begin
        mul_a = $signed({{(MA_W-RQ_REM_W){1'b0}}, rq_rem_r});
        mul_b = $signed({1'b0, RQ_RECIP});
      end
      OP_RQ_MULQ1: begin
        mul_a = $signed({{(MA_W-RQ_Q1_W){1'b0}}, prod_r[RQ_SH1+RQ_Q1_W-1:RQ_SH1]});
        mul_b = $signed({1'b0, RQ_DIV});
      end
      default: ;
    endcase
    sdiff     = $signed({1'b0, meas_r}) - $signed({1'b0, targ_r});
    div_start = is_div_op(cmd.op);
    div_a     = prod_r;
    div_b     = t_r;
    unique case (cmd.op)
      OP_DIV_E: begin div_a = PROD_W'($signed({sdiff, 14'b0})); div_b = DVS_W'(targ_r); end
      default: ;
    endcase
  end

  vpid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quo)
  );

  assign status.div_done = div_done;
  assign status.out_free = !ov_r || out_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skp_r <= '0; ski_r <= '0; skd_r <= '0;
      tkp_r <= '0; tki_r <= '0; tkd_r <= '0;
      lim_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SPEED_KP: skp_r <= $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_SPEED_KI: ski_r <= $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_SPEED_KD: skd_r <= $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_STEER_KP: tkp_r <= $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_STEER_KI: tki_r <= $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_STEER_KD: tkd_r <= $signed(cfg_wdata[GAIN_W-1:0]);
        CFG_LIMIT:    lim_r <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller state carried between items.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lse_r  <= '0;
      sint_r <= '0;
      ldev_r <= '0;
      hint_r <= '0;
    end else begin
      unique case (cmd.op)
        OP_WR_SI:    if (!t0) sint_r <= sint_r + dq_r;
        OP_CLAMP_SI: begin
          if (sint_r > lim_pos) sint_r <= lim_pos;
          else if (sint_r < lim_neg) sint_r <= lim_neg;
        end
        OP_WR_HI: begin
          if (!t0) begin
            if (hsum > I32_MAX) hint_r <= ERR_W'(I32_MAX);
            else if (hsum < I32_MIN) hint_r <= ERR_W'(I32_MIN);
            else hint_r <= ERR_W'(hsum);
          end
        end
        OP_PUBLISH: begin
          lse_r  <= e_r;
          ldev_r <= dev_r;
        end
        default: ;
      endcase
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meas_r  <= in_measured_speed;
      targ_r  <= in_target_speed;
      dev_r   <= in_heading_deviation;
      t_r     <= in_elapsed_time;
      fault_r <= {in_elapsed_time == '0, in_target_speed == '0};
    end
    unique case (cmd.op)
      OP_MUL_ET, OP_MUL_DT, OP_MUL_DIFF, OP_MUL_SKP, OP_MUL_SKI, OP_MUL_SKD,
      OP_MUL_TKP, OP_MUL_TKI, OP_MUL_TKD, OP_RQ_MUL0, OP_RQ_MUL1:
        prod_r <= mul_a * mul_b;
      // Take the magnitude of the product, already divided by 64.
      OP_RQ_LOAD: begin
        rq_y_r   <= prod_mag[RQ_Y_W+RQ_SH_IN-1:RQ_SH_IN];
        rq_neg_r <= prod_r[PROD_W-1];
      end
      // First quotient estimate, and its multiple of 15625.
      OP_RQ_MULQ0: begin
        prod_r <= mul_a * mul_b;
        rq_q_r <= prod_r[RQ_SH0+ERR_W-1:RQ_SH0];
      end
      // The remainder fits in its low bits, so a narrow subtraction is exact.
      OP_RQ_R0: rq_rem_r <= rq_y_r[RQ_REM_W-1:0] - prod_r[RQ_REM_W-1:0];
      // Second estimate on the remainder.
      OP_RQ_MULQ1: begin
        prod_r <= mul_a * mul_b;
        rq_q_r <= rq_q_r + ERR_W'(prod_r[RQ_SH1+RQ_Q1_W-1:RQ_SH1]);
      end
      OP_RQ_R1: rq_rem_r <= rq_rem_r - prod_r[RQ_REM_W-1:0];
      // Last correction step and the sign, as one add: -(q + c) = ~q + !c.
      OP_RQ_FIN: begin
        if (rq_neg_r) dq_r <= $signed(~rq_q_r + ERR_W'(!rq_carry));
        else dq_r <= $signed(rq_q_r + ERR_W'(rq_carry));
      end
      OP_WR_E:   e_r <= targ0 ? '0 : ERR_W'(quo);
      OP_SUB_E:  diff_r <= MA_W'(e_r) - MA_W'(lse_r);
      OP_SUB_D:  diff_r <= MA_W'(dev_r) - MA_W'(ldev_r);
      OP_WR_DE: begin
        if (t0) de_r <= '0;
        else if (quo > Q32_MAX) de_r <= ERR_W'(Q32_MAX);
        else if (quo < Q32_MIN) de_r <= ERR_W'(Q32_MIN);
        else de_r <= ERR_W'(quo);
      end
      OP_WR_DD:     dd_r  <= t0 ? '0 : DD_W'(quo);
      OP_ACC_FIRST: acc_r <= ACC_W'(prod_r);
      OP_ACC_ADD:   acc_r <= acc_r + ACC_W'(prod_r);
      // Divide by 2^7 or 2^6, truncating toward zero.
      OP_SCALE_SPD: acc_r <= (acc_r + (acc_r[ACC_W-1] ? ACC_W'(127) : ACC_W'(0))) >>> 7;
      OP_SCALE_STR: acc_r <= (acc_r + (acc_r[ACC_W-1] ? ACC_W'(63) : ACC_W'(0))) >>> 6;
      OP_SPEED_OUT: begin
        if (acc_r[ACC_W-1]) begin
          thr_r <= (acc_neg > A_THR) ? THR_MAX : acc_neg[OUT_W-1:0];
          brk_r <= '0;
        end else begin
          thr_r <= '0;
          brk_r <= (acc_r > A_BRK) ? BRK_MAX : acc_r[OUT_W-1:0];
        end
      end
      OP_STEER_OUT: begin
        if (acc_r > A_S_MAX) str_r <= 16'sh7FFF;
        else if (acc_r < A_S_MIN) str_r <= -16'sh8000;
        else str_r <= acc_r[OUT_W-1:0];
      end
      default: ;
    endcase
  end

  // Output register; a finished result waits here for its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.op == OP_PUBLISH) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
    if (cmd.op == OP_PUBLISH) begin
      othr_r <= thr_r;
      obrk_r <= brk_r;
      ostr_r <= str_r;
      oflt_r <= fault_r;
    end
  end

  assign out_valid        = ov_r;
  assign out_throttle     = othr_r;
  assign out_brake        = obrk_r;
  assign out_steer        = ostr_r;
  assign out_divide_fault = oflt_r;

endmodule

/* hw/rtl/vehicle_pid_throttle_brake_steer_core.sv */
// Longitudinal and lateral PID core: top level joining sequencer and datapath.
// An item runs three serial divisions on the shared divider and the datapath steps
// between them; its result then waits in the output register for its transfer.
// A new item is taken only when the previous one has been published; it may be
// taken while that result still waits in the output register.
// Reset (synchronous, active low) clears gains to zero, the integral limit to 5.0,
// and the last errors and both integrals to zero.
module vehicle_pid_throttle_brake_steer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [vpid_pkg::SPD_W-1:0]         in_measured_speed,
  input  logic [vpid_pkg::SPD_W-1:0]         in_target_speed,
  input  logic signed [vpid_pkg::DEV_W-1:0]  in_heading_deviation,
  input  logic [vpid_pkg::TIME_W-1:0]        in_elapsed_time,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [vpid_pkg::OUT_W-1:0]         out_throttle,
  output logic [vpid_pkg::OUT_W-1:0]         out_brake,
  output logic signed [vpid_pkg::OUT_W-1:0]  out_steer,
  output logic [vpid_pkg::FLT_W-1:0]         out_divide_fault,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vpid_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [vpid_pkg::CDAT_W-1:0]        cfg_wdata
);
  import vpid_pkg::*;

  cmd_t    cmd;
  status_t status;

  vpid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vpid_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_measured_speed    (in_measured_speed),
    .in_target_speed      (in_target_speed),
    .in_heading_deviation (in_heading_deviation),
    .in_elapsed_time      (in_elapsed_time),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_throttle         (out_throttle),
    .out_brake            (out_brake),
    .out_steer            (out_steer),
    .out_divide_fault     (out_divide_fault)
  );

endmodule
